[sv/tm_pkg.sv]
`timescale 1ns / 1ps
// Package for the Turing machine step engine: sizes, field widths, item kinds,
// rule entry and tape control types. No dependencies.
package tm_pkg;

  localparam int TAPE_CELLS  = 1024;
  localparam int NUM_STATES  = 16;
  localparam int NUM_SYMBOLS = 6;

  localparam int HALT_LAST  = NUM_STATES + 2;
  localparam int RULE_COUNT = NUM_STATES * NUM_SYMBOLS;
  localparam int TAPE_AW    = $clog2(TAPE_CELLS);
  localparam int RULE_AW    = $clog2(RULE_COUNT);

  // field widths
  localparam int KIND_W   = 3;
  localparam int RSTATE_W = 4;
  localparam int STATE_W  = 5;
  localparam int SYM_W    = 3;
  localparam int POS_W    = 10;
  localparam int TICK_W   = 32;

  localparam int IN_DATA_W    = 32;
  localparam int OUT_FIELDS_W = STATE_W + POS_W + SYM_W + 1 + 1 + TICK_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    K_STEP       = 3'd0,
    K_LOAD_RULE  = 3'd1,
    K_WRITE_CELL = 3'd2,
    K_PLACE_HEAD = 3'd3,
    K_RESTART    = 3'd4
  } kind_e;

  typedef struct packed {
    logic [STATE_W-1:0] next;
    logic [SYM_W-1:0]   wsym;
    logic               right;
  } rule_t;

  typedef struct packed {
    logic clear;
    logic shift;
    logic right;
  } tape_ctrl_t;

endpackage

[sv/tm_cell.sv]
`timescale 1ns / 1ps
// One tape cell of the rotating tape ring: holds a symbol, clears it, takes a direct write,
// or takes a neighbor's symbol on a shift, in that priority. Depends on tm_pkg.
module tm_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tm_pkg::tape_ctrl_t       ctrl_i,
  input  logic                     we_i,
  input  logic [tm_pkg::SYM_W-1:0] wdata_i,
  input  logic [tm_pkg::SYM_W-1:0] left_i,
  input  logic [tm_pkg::SYM_W-1:0] right_i,
  output logic [tm_pkg::SYM_W-1:0] sym_o
);
  import tm_pkg::*;

  logic [SYM_W-1:0] sym_d, sym_q;

  always_comb begin
    priority if (ctrl_i.clear) begin
      sym_d = '0;
    end else if (we_i) begin
      sym_d = wdata_i;
    end else if (ctrl_i.shift) begin
      // head moving right pulls the ring one place toward cell 0
      sym_d = ctrl_i.right ? right_i : left_i;
    end else begin
      sym_d = sym_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_q <= '0;
    end else begin
      sym_q <= sym_d;
    end
  end

  assign sym_o = sym_q;

endmodule

[sv/tm_rules.sv]
`timescale 1ns / 1ps
// Rule table: one-write, one-read memory with registered read and per-entry
// valid bits so that unwritten entries read as zero. Depends on tm_pkg.
module tm_rules (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clr_i,
  input  logic                       we_i,
  input  logic [tm_pkg::RULE_AW-1:0] waddr_i,
  input  tm_pkg::rule_t              wdata_i,
  input  logic [tm_pkg::RULE_AW-1:0] raddr_i,
  output tm_pkg::rule_t              rdata_o
);
  import tm_pkg::*;

  rule_t                 mem_q [RULE_COUNT];
  rule_t                 rd_q;
  logic [RULE_COUNT-1:0] valid_q;
  logic                  rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (clr_i) begin
        valid_q <= '0;
      end else if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rd_valid_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rd_valid_q ? rd_q : '0;

endmodule

[sv/turing_machine_step_engine.sv]
`timescale 1ns / 1ps
// Turing machine step engine, top level. Tape is a ring of tm_cell kept aligned
// so the head always sits at cell 0; rules live in tm_rules. Depends on tm_pkg, tm_cell and tm_rules.
// Each word passes idle, act and emit; place head adds a rotate state before emit, the ring
// turning one cell a cycle over at most TAPE_CELLS/2 cells. A new word is accepted only in
// idle, after the previous result is registered; emit waits until the output slot is free.
// Reset (rst_ni low, async): tape zero, rules read as zero, head at the tape center, state 0.
module turing_machine_step_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // rule_state, rule_symbol, rule_next_state, rule_write_symbol, rule_move_right,
  // position, cell_symbol, zero pad
  input  logic [tm_pkg::IN_DATA_W-1:0]  s_tdata,
  // kind
  input  logic [tm_pkg::KIND_W-1:0]     s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // machine_state, head_position, symbol_under_head, halted, direction, ticks, zero pad
  output logic [tm_pkg::OUT_DATA_W-1:0] m_tdata
);
  import tm_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_ACT, S_ROT, S_EMIT} fsm_e;

  fsm_e                  fsm_q;
  kind_e                 kind_q;
  logic [RSTATE_W-1:0]   rs_q;
  logic [SYM_W-1:0]      rsym_q;
  logic [STATE_W-1:0]    rnext_q;
  logic [SYM_W-1:0]      rw_q;
  logic                  rr_q;
  logic [POS_W-1:0]      pos_q;
  logic [SYM_W-1:0]      cs_q;
  logic [TAPE_AW-1:0]    off_q;
  logic [TAPE_AW-1:0]    target_q;
  logic                  rot_right_q;

  logic [STATE_W-1:0]    mstate_q;
  logic [TAPE_AW-1:0]    head_q;
  logic                  dir_q;
  logic                  halt_q;
  logic [TICK_W-1:0]     ticks_q;
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  // input word fields
  logic [POS_W-1:0]      in_pos;
  assign in_pos = s_tdata[25:16];

  // tape ring
  logic [SYM_W-1:0]      cell_sym [TAPE_CELLS];
  logic [SYM_W-1:0]      feed     [TAPE_CELLS];
  logic [TAPE_CELLS-1:0] cell_we;
  tape_ctrl_t            ring_ctrl;
  logic [SYM_W-1:0]      ring_w;
  logic [SYM_W-1:0]      sym0;

  // rules
  rule_t                 rule;
  rule_t                 rule_wdata;
  logic                  rule_we;
  logic [RULE_AW-1:0]    rule_waddr;
  logic [RULE_AW-1:0]    rule_raddr;
  logic                  rd_ok;

  logic                  in_fire;
  logic                  act_step, step_go, step_move, rot_busy;
  logic                  wr_cell, rule_clr;
  logic [TAPE_AW:0]      p_ext, h_ext, off_w;
  logic [TAPE_AW-1:0]    head_inc, head_dec, head_mv;
  logic                  mv_right;

  assign sym0    = cell_sym[0];
  assign in_fire = s_tvalid && s_tready;

  // distance from head to requested cell, modulo the tape length
  assign p_ext = {1'b0, TAPE_AW'(in_pos)};
  assign h_ext = {1'b0, head_q};
  assign off_w = (p_ext >= h_ext) ? (p_ext - h_ext)
                                  : (p_ext + (TAPE_AW+1)'(TAPE_CELLS) - h_ext);

  assign head_inc = (head_q == TAPE_AW'(TAPE_CELLS - 1)) ? '0 : head_q + TAPE_AW'(1);
  assign head_dec = (head_q == '0) ? TAPE_AW'(TAPE_CELLS - 1) : head_q - TAPE_AW'(1);

  assign rd_ok      = (int'(mstate_q) < NUM_STATES) && (int'(sym0) < NUM_SYMBOLS);
  assign rule_raddr = rd_ok ? RULE_AW'(int'(mstate_q) * NUM_SYMBOLS + int'(sym0)) : '0;

  assign act_step  = (fsm_q == S_ACT) && (kind_q == K_STEP);
  assign step_go   = act_step && !halt_q && rd_ok;
  assign step_move = step_go && (int'(rule.next) < NUM_STATES);
  assign rot_busy  = (fsm_q == S_ROT) && (head_q != target_q);
  assign mv_right  = step_move ? rule.right : rot_right_q;
  assign head_mv   = mv_right ? head_inc : head_dec;

  assign wr_cell = (fsm_q == S_ACT) && (kind_q == K_WRITE_CELL) &&
                   (int'(pos_q) < TAPE_CELLS) && (int'(cs_q) < NUM_SYMBOLS);
  assign rule_clr = (fsm_q == S_ACT) && (kind_q == K_RESTART);
  assign rule_we  = (fsm_q == S_ACT) && (kind_q == K_LOAD_RULE) &&
                    (int'(rs_q) < NUM_STATES) && (int'(rsym_q) < NUM_SYMBOLS) &&
                    (int'(rnext_q) <= HALT_LAST) && (int'(rw_q) < NUM_SYMBOLS);
  assign rule_waddr = RULE_AW'(int'(rs_q) * NUM_SYMBOLS + int'(rsym_q));
  assign rule_wdata = '{next: rnext_q, wsym: rw_q, right: rr_q};

  assign ring_ctrl = '{clear: rule_clr, shift: step_move || rot_busy, right: mv_right};
  // on a step the written symbol leaves cell 0 while the ring turns
  assign ring_w    = step_move ? rule.wsym : sym0;

  tm_rules u_rules (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (rule_clr),
    .we_i    (rule_we),
    .waddr_i (rule_waddr),
    .wdata_i (rule_wdata),
    .raddr_i (rule_raddr),
    .rdata_o (rule)
  );

  for (genvar k = 0; k < TAPE_CELLS; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign feed[k] = ring_w;
    end else begin : g_body
      assign feed[k] = cell_sym[k];
    end
    assign cell_we[k] = wr_cell && (off_q == TAPE_AW'(k));

    tm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ring_ctrl),
      .we_i    (cell_we[k]),
      .wdata_i (cs_q),
      .left_i  (feed[(k + TAPE_CELLS - 1) % TAPE_CELLS]),
      .right_i (feed[(k + 1) % TAPE_CELLS]),
      .sym_o   (cell_sym[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= S_IDLE;
      kind_q      <= K_STEP;
      rs_q        <= '0;
      rsym_q      <= '0;
      rnext_q     <= '0;
      rw_q        <= '0;
      rr_q        <= 1'b0;
      pos_q       <= '0;
      cs_q        <= '0;
      off_q       <= '0;
      target_q    <= '0;
      rot_right_q <= 1'b0;
      mstate_q    <= '0;
      head_q      <= TAPE_AW'(TAPE_CELLS / 2);
      dir_q       <= 1'b0;
      halt_q      <= 1'b0;
      ticks_q     <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // the emit state owns the valid flag itself
      if (m_tready && fsm_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end
      unique case (fsm_q)
        S_IDLE: begin
          if (in_fire) begin
            kind_q  <= kind_e'(s_tuser);
            rs_q    <= s_tdata[3:0];
            rsym_q  <= s_tdata[6:4];
            rnext_q <= s_tdata[11:7];
            rw_q    <= s_tdata[14:12];
            rr_q    <= s_tdata[15];
            pos_q   <= in_pos;
            cs_q    <= s_tdata[28:26];
            off_q   <= off_w[TAPE_AW-1:0];
            fsm_q   <= S_ACT;
          end
        end
        S_ACT: begin
          fsm_q <= S_EMIT;
          unique case (kind_q)
            K_STEP: begin
              if (step_go) begin
                mstate_q <= rule.next;
                if (step_move) begin
                  dir_q   <= rule.right;
                  head_q  <= head_mv;
                  ticks_q <= ticks_q + TICK_W'(1);
                end else begin
                  halt_q <= 1'b1;
                end
              end
            end
            K_PLACE_HEAD: begin
              if (int'(pos_q) < TAPE_CELLS) begin
                target_q    <= TAPE_AW'(pos_q);
                rot_right_q <= (int'(off_q) <= TAPE_CELLS / 2);
                fsm_q       <= S_ROT;
              end
            end
            K_RESTART: begin
              mstate_q <= '0;
              head_q   <= TAPE_AW'(TAPE_CELLS / 2);
              dir_q    <= 1'b0;
              halt_q   <= 1'b0;
              ticks_q  <= '0;
            end
            default: ;
          endcase
        end
        S_ROT: begin
          if (rot_busy) begin
            head_q <= head_mv;
          end else begin
            fsm_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_q || m_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}}, ticks_q, dir_q, halt_q,
                            sym0, POS_W'(head_q), mstate_q};
            fsm_q       <= S_IDLE;
          end
        end
        default: fsm_q <= S_IDLE;
      endcase
    end
  end

  assign s_tready = (fsm_q == S_IDLE);
  assign m_tvalid = out_valid_q;
  assign m_tdata  = out_data_q;

endmodule

[sv/tm_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the Turing machine step engine, bound to the top level.
// Depends on tm_pkg.
module tm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [tm_pkg::OUT_DATA_W-1:0] m_tdata
);
  import tm_pkg::*;

  // held result word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // one word at a time: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while previous word still in work");

  // a new result only appears after the engine was busy
  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared without work cycle");

  // running machine never reports a halting state
  a_run_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tdata[18] |-> int'(m_tdata[4:0]) < NUM_STATES)
    else $error("halting state reported while not halted");

  a_sym_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> int'(m_tdata[17:15]) < NUM_SYMBOLS)
    else $error("symbol under head out of range");

endmodule

bind turing_machine_step_engine tm_checker u_tm_checker (.*);

[tb/turing_machine_step_engine_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for turing_machine_step_engine: a directed table checked against its
// own expected words, then random rule programs with stepping runs, checked word by word
// against a behavioral machine. Depends on tm_pkg and the engine RTL.
module turing_machine_step_engine_test;
  import tm_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  // input word fields, lowest bits last
  typedef struct packed {
    logic [SYM_W-1:0]    cell_sym;
    logic [POS_W-1:0]    pos;
    logic                move_right;
    logic [SYM_W-1:0]    write_sym;
    logic [STATE_W-1:0]  nxt_state;
    logic [SYM_W-1:0]    rule_sym;
    logic [RSTATE_W-1:0] rule_state;
  } cmd_t;

  // result word fields, lowest bits last
  typedef struct packed {
    logic [TICK_W-1:0]  ticks;
    logic               dir;
    logic               halted;
    logic [SYM_W-1:0]   sym;
    logic [POS_W-1:0]   head;
    logic [STATE_W-1:0] state;
  } status_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    cmd_t              cmd;
    bit                typed;
    status_t           want;
  } drill_t;

  logic                  clk_i    = 1'b0;
  logic                  rst_ni   = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic [KIND_W-1:0]     s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  turing_machine_step_engine u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // behavioral machine
  logic [SYM_W-1:0]   tape_mem [TAPE_CELLS];
  rule_t              rule_mem [RULE_COUNT];
  logic [STATE_W-1:0] cur_state;
  logic [POS_W-1:0]   cur_head;
  logic               cur_dir;
  logic               cur_halted;
  logic [TICK_W-1:0]  cur_ticks;

  status_t expected_status_q [$];
  int      mismatches = 0;
  int      sent       = 0;
  bit      calm       = 1'b0;
  drill_t  drill [25];

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic void clear_machine();
    foreach (tape_mem[i]) tape_mem[i] = '0;
    foreach (rule_mem[i]) rule_mem[i] = '0;
    cur_state  = '0;
    cur_head   = POS_W'(TAPE_CELLS / 2);
    cur_dir    = 1'b0;
    cur_halted = 1'b0;
    cur_ticks  = '0;
  endfunction

  function automatic status_t machine_apply(logic [KIND_W-1:0] kind, cmd_t c);
    status_t s;
    rule_t   r;
    int      idx;
    case (kind)
      K_STEP: begin
        if (!cur_halted && cur_state < NUM_STATES) begin
          idx = cur_state * NUM_SYMBOLS + tape_mem[cur_head];
          r = rule_mem[idx];
          cur_state = r.next;
          if (r.next >= NUM_STATES) begin
            cur_halted = 1'b1;
          end else begin
            cur_dir = r.right;
            tape_mem[cur_head] = r.wsym;
            // tape is exactly 2**POS_W cells, so the head wraps by itself
            cur_head = r.right ? cur_head + POS_W'(1) : cur_head - POS_W'(1);
            cur_ticks = cur_ticks + TICK_W'(1);
          end
        end
      end
      K_LOAD_RULE: begin
        if (c.rule_sym < NUM_SYMBOLS && c.nxt_state <= HALT_LAST &&
            c.write_sym < NUM_SYMBOLS) begin
          idx = c.rule_state * NUM_SYMBOLS + c.rule_sym;
          rule_mem[idx] = '{next: c.nxt_state, wsym: c.write_sym, right: c.move_right};
        end
      end
      K_WRITE_CELL: begin
        if (c.cell_sym < NUM_SYMBOLS) tape_mem[c.pos] = c.cell_sym;
      end
      K_PLACE_HEAD: cur_head = c.pos;
      K_RESTART:    clear_machine();
      default: ;
    endcase
    s.state  = cur_state;
    s.head   = cur_head;
    s.sym    = tape_mem[cur_head];
    s.halted = cur_halted;
    s.dir    = cur_dir;
    s.ticks  = cur_ticks;
    return s;
  endfunction

  function automatic cmd_t rule_cmd(int rs, int rsym, int nxt, int ws, logic rr);
    cmd_t c = '0;
    c.rule_state = RSTATE_W'(rs);
    c.rule_sym   = SYM_W'(rsym);
    c.nxt_state  = STATE_W'(nxt);
    c.write_sym  = SYM_W'(ws);
    c.move_right = rr;
    return c;
  endfunction

  function automatic cmd_t cell_cmd(int pos, int cs);
    cmd_t c = '0;
    c.pos      = POS_W'(pos);
    c.cell_sym = SYM_W'(cs);
    return c;
  endfunction

  function automatic status_t mk_status(int st, int hd, int sym, int hlt, int dir, int tk);
    return '{ticks: TICK_W'(tk), dir: 1'(dir), halted: 1'(hlt), sym: SYM_W'(sym),
             head: POS_W'(hd), state: STATE_W'(st)};
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  task automatic send(logic [KIND_W-1:0] kind, cmd_t cmd, bit typed, status_t typed_st);
    status_t want;
    while (!calm && $urandom_range(0, 99) < 35) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{(IN_DATA_W - $bits(cmd_t)){1'b0}}, cmd};
    do @(posedge clk_i); while (!s_tready);
    sent++;
    calm = sent >= 700 && sent < 900;
    want = machine_apply(kind, cmd);
    expected_status_q.push_back(typed ? typed_st : want);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    m_tready <= calm || ($urandom_range(0, 99) >= 35);
  end

  always @(posedge clk_i) begin : result_check
    status_t got;
    status_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      got = m_tdata[OUT_FIELDS_W-1:0];
      if (expected_status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: unexpected word %h", $time, got);
      end else begin
        want = expected_status_q.pop_front();
        check_field("machine_state", 32'(want.state), 32'(got.state));
        check_field("head_position", 32'(want.head), 32'(got.head));
        check_field("symbol_under_head", 32'(want.sym), 32'(got.sym));
        check_field("halted", 32'(want.halted), 32'(got.halted));
        check_field("direction", 32'(want.dir), 32'(got.dir));
        check_field("ticks", want.ticks, got.ticks);
      end
    end
  end

  initial begin
    status_t          rst_st;
    cmd_t             c;
    logic [31:0]      raw;
    logic [POS_W-1:0] p;
    int               prog;
    int               n;

    clear_machine();
    rst_st = mk_status(0, 512, 0, 0, 0, 0);
    drill[0]  = '{K_RESTART, '0, 1'b1, rst_st};
    drill[1]  = '{KIND_SPARE_LO, '0, 1'b1, rst_st};
    drill[2]  = '{KIND_SPARE_HI, '1, 1'b1, rst_st};
    drill[3]  = '{K_PLACE_HEAD, cell_cmd(0, 0), 1'b1, mk_status(0, 0, 0, 0, 0, 0)};
    drill[4]  = '{K_WRITE_CELL, cell_cmd(0, 5), 1'b1, mk_status(0, 0, 5, 0, 0, 0)};
    drill[5]  = '{K_WRITE_CELL, cell_cmd(1023, 3), 1'b1, mk_status(0, 0, 5, 0, 0, 0)};
    // bad symbols leave the cell alone
    drill[6]  = '{K_WRITE_CELL, cell_cmd(0, 6), 1'b1, mk_status(0, 0, 5, 0, 0, 0)};
    drill[7]  = '{K_WRITE_CELL, cell_cmd(0, 7), 1'b1, mk_status(0, 0, 5, 0, 0, 0)};
    drill[8]  = '{K_LOAD_RULE, rule_cmd(0, 5, 15, 4, 0), 1'b0, '0};
    // left off cell 0 wraps to the far end
    drill[9]  = '{K_STEP, '0, 1'b1, mk_status(15, 1023, 3, 0, 0, 1)};
    drill[10] = '{K_LOAD_RULE, rule_cmd(15, 3, 1, 2, 1), 1'b0, '0};
    drill[11] = '{K_STEP, '0, 1'b1, mk_status(1, 0, 4, 0, 1, 2)};
    // out-of-range rule loads must not land; the last load, a halting rule, does
    drill[12] = '{K_LOAD_RULE, rule_cmd(1, 6, 3, 1, 1), 1'b0, '0};
    drill[13] = '{K_LOAD_RULE, rule_cmd(1, 7, 3, 1, 1), 1'b0, '0};
    drill[14] = '{K_LOAD_RULE, rule_cmd(1, 4, 19, 1, 1), 1'b0, '0};
    drill[15] = '{K_LOAD_RULE, rule_cmd(1, 4, 31, 1, 1), 1'b0, '0};
    drill[16] = '{K_LOAD_RULE, rule_cmd(1, 4, 2, 6, 1), 1'b0, '0};
    drill[17] = '{K_LOAD_RULE, rule_cmd(1, 4, 16, 5, 0), 1'b0, '0};
    drill[18] = '{K_STEP, '0, 1'b1, mk_status(16, 0, 4, 1, 1, 2)};
    drill[19] = '{K_STEP, '0, 1'b1, mk_status(16, 0, 4, 1, 1, 2)};
    // head placement and cell writes still work while halted
    drill[20] = '{K_PLACE_HEAD, cell_cmd(1023, 0), 1'b1, mk_status(16, 1023, 2, 1, 1, 2)};
    drill[21] = '{K_WRITE_CELL, cell_cmd(1023, 1), 1'b1, mk_status(16, 1023, 1, 1, 1, 2)};
    drill[22] = '{K_RESTART, '0, 1'b1, rst_st};
    drill[23] = '{K_LOAD_RULE, rule_cmd(0, 0, 17, 3, 1), 1'b0, '0};
    drill[24] = '{K_STEP, '0, 1'b1, mk_status(17, 512, 0, 1, 0, 0)};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (drill[i]) send(drill[i].kind, drill[i].cmd, drill[i].typed, drill[i].want);

    // random rule programs, each followed by a run of steps
    prog = 0;
    while (sent < 1500) begin
      if (prog % 10 == 0) drain();
      if (cur_halted ? $urandom_range(0, 9) < 8 : $urandom_range(0, 6) == 0) begin
        raw = $urandom;
        send(K_RESTART, raw[$bits(cmd_t)-1:0], 1'b0, '0);
      end
      n = $urandom_range(3, 14);
      repeat (n) begin
        raw = $urandom;
        if ($urandom_range(0, 9) == 0) begin
          c = raw[$bits(cmd_t)-1:0];
        end else begin
          c = rule_cmd($urandom_range(0, NUM_STATES - 1), $urandom_range(0, NUM_SYMBOLS - 1),
                       ($urandom_range(0, 99) < 8) ? $urandom_range(NUM_STATES, HALT_LAST)
                                                  : $urandom_range(0, NUM_STATES - 1),
                       $urandom_range(0, NUM_SYMBOLS - 1), raw[0]);
        end
        send(K_LOAD_RULE, c, 1'b0, '0);
      end
      n = $urandom_range(0, 6);
      repeat (n) begin
        p = cur_head + POS_W'($urandom_range(0, 16)) - POS_W'(8);
        send(K_WRITE_CELL, cell_cmd(int'(p), $urandom_range(0, 7)), 1'b0, '0);
      end
      if ($urandom_range(0, 1) == 0) begin
        // placement cost grows with distance, so most jumps stay short
        if ($urandom_range(0, 49) == 0) p = POS_W'($urandom_range(0, TAPE_CELLS - 1));
        else p = cur_head + POS_W'($urandom_range(0, 16)) - POS_W'(8);
        send(K_PLACE_HEAD, cell_cmd(int'(p), $urandom_range(0, 7)), 1'b0, '0);
      end
      n = $urandom_range(4, 40);
      repeat (n) begin
        raw = $urandom;
        send(K_STEP, raw[$bits(cmd_t)-1:0], 1'b0, '0);
      end
      if ($urandom_range(0, 3) == 0) begin
        raw = $urandom;
        send(KIND_W'($urandom_range(0, 7)), raw[$bits(cmd_t)-1:0], 1'b0, '0);
      end
      prog++;
    end

    drain();
    repeat (600) @(posedge clk_i);
    if (mismatches == 0 && expected_status_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
sv/tm_pkg.sv
sv/tm_cell.sv
sv/tm_rules.sv
sv/turing_machine_step_engine.sv
sv/tm_checker.sv
tb/turing_machine_step_engine_test.sv
